// ----- rtl/ebet_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebet_pkg
// Shared types, codes and tables of the encoder and button event tracker.
// ----------------------------------------------------------------------------
package ebet_pkg;

    // Request kinds carried in tuser of the input channel.
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_EVENTS = 2'd1,
        REQ_TICKS  = 2'd2
    } req_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_VARIANT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 1'd1;

    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] LONG_PRESS_RESET = 32'd16000000;

    // Pin snapshot layout.
    localparam int PIN_W       = 8;
    localparam int PIN_QUAD_LO = 1;
    localparam int PIN_ENC_SW  = 3;
    localparam int PIN_BACK_SW = 7;

    localparam int STAMP_W = 32;
    localparam int TICK_W  = 32;

    // Channel widths.
    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Sticky flag positions.
    localparam int STK_ENC_SHORT  = 0;
    localparam int STK_BACK_SHORT = 1;
    localparam int STK_ENC_LONG   = 2;
    localparam int STK_BACK_LONG  = 3;

    // Quadrature transition table, indexed by {previous pair, current pair}.
    // Returns a signed step of -1, 0 or +1.
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/encoder_button_event_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_button_event_tracker
// Quadrature encoder decoder with two press/release-timed push buttons.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A beat is taken into an
// input register and processed by one pass of short logic against the tracker
// state. Its result moves into the output register once the output is free
// or being taken. While the output is free, a new beat can be accepted
// every cycle. While a result waits on the output, the input register takes
// one more beat and then holds s_tready low until the result is taken. The
// longest path is the 32-bit tick delta subtract feeding the signed compare
// with the rotation tracker.
// Configuration writes are always accepted and take effect the next cycle.
module encoder_button_event_tracker
    import ebet_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // bits: [7:0] pin_sample, [39:8] cycle_stamp, [40] reset_baseline, rest zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // bits: [1:0] req_type
    input  wire logic [S_TUSER_W-1:0]  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // bits: [0] enc_held, [1] back_held, [2] enc_short, [3] back_short,
    // [4] enc_long, [5] back_long, [6] rot_cw, [7] rot_ccw,
    // [39:8] tick_count, [47:40] pin_state
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register
    logic                 in_vld_reg;
    req_t                 in_req_reg;
    logic [PIN_W-1:0]     in_pins_reg;
    logic [STAMP_W-1:0]   in_stamp_reg;
    logic                 in_rebase_reg;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Configuration
    logic                 board_variant_reg;
    logic [31:0]          long_press_reg;

    // Tracker state
    logic [PIN_W-1:0]     prev_pins_reg, prev_pins_next;
    logic                 primed_reg, primed_next;
    logic [1:0]           prev_quad_reg, prev_quad_next;
    logic [TICK_W-1:0]    step_sum_reg, step_sum_next;
    logic [TICK_W-1:0]    baseline_reg, baseline_next;
    logic [TICK_W-1:0]    reported_reg, reported_next;
    logic [STAMP_W-1:0]   enc_stamp_reg, enc_stamp_next;
    logic [STAMP_W-1:0]   back_stamp_reg, back_stamp_next;
    logic [1:0]           held_reg, held_next;
    logic [3:0]           sticky_reg, sticky_next;

    logic                 s_accept;
    logic                 advance;

    logic [1:0]           quad;
    logic [PIN_W-1:0]     rising;
    logic [PIN_W-1:0]     falling;
    logic signed [1:0]    qstep;
    logic [TICK_W-1:0]    delta;
    logic [TICK_W-1:0]    scaled;
    logic [3:0]           sticky_out;
    logic                 rot_cw;
    logic                 rot_ccw;
    logic [TICK_W-1:0]    tick_out;

    assign advance   = in_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    assign quad    = in_pins_reg[PIN_QUAD_LO +: 2];
    assign rising  = ~prev_pins_reg & in_pins_reg;
    assign falling = prev_pins_reg & ~in_pins_reg;
    assign qstep   = quad_step({prev_quad_reg, quad});

    // Tick delta since the baseline; the compact board reports quarter steps.
    assign delta  = step_sum_reg - baseline_reg;
    assign scaled = board_variant_reg ? TICK_W'($signed(delta) >>> 2) : delta;

    always_comb begin
        prev_pins_next  = prev_pins_reg;
        primed_next     = primed_reg;
        prev_quad_next  = prev_quad_reg;
        step_sum_next   = step_sum_reg;
        baseline_next   = baseline_reg;
        reported_next   = reported_reg;
        enc_stamp_next  = enc_stamp_reg;
        back_stamp_next = back_stamp_reg;
        held_next       = held_reg;
        sticky_next     = sticky_reg;
        rot_cw          = 1'b0;
        rot_ccw         = 1'b0;
        tick_out        = '0;

        if (advance && in_req_reg == REQ_SAMPLE) begin
            prev_pins_next = in_pins_reg;
            prev_quad_next = quad;
            primed_next    = 1'b1;
            // The first sample only sets the reference for edges and the pair.
            if (primed_reg) begin
                if (falling[PIN_ENC_SW]) begin
                    enc_stamp_next = in_stamp_reg;
                end
                if (falling[PIN_BACK_SW]) begin
                    back_stamp_next = in_stamp_reg;
                end
                held_next = {~in_pins_reg[PIN_BACK_SW], ~in_pins_reg[PIN_ENC_SW]};
                if (rising[PIN_ENC_SW]) begin
                    if ((in_stamp_reg - enc_stamp_reg) > long_press_reg) begin
                        sticky_next[STK_ENC_LONG] = 1'b1;
                    end else begin
                        sticky_next[STK_ENC_SHORT] = 1'b1;
                    end
                end
                if (rising[PIN_BACK_SW]) begin
                    if ((in_stamp_reg - back_stamp_reg) > long_press_reg) begin
                        sticky_next[STK_BACK_LONG] = 1'b1;
                    end else begin
                        sticky_next[STK_BACK_SHORT] = 1'b1;
                    end
                end
                step_sum_next = step_sum_reg - {{(TICK_W-2){qstep[1]}}, qstep};
            end
        end

        // Event reads report the flags as they stood before being cleared.
        sticky_out = sticky_next;

        if (advance && in_req_reg == REQ_EVENTS) begin
            if ($signed(scaled) < $signed(reported_reg)) begin
                rot_ccw       = 1'b1;
                reported_next = reported_reg - TICK_W'(1);
            end else if ($signed(scaled) > $signed(reported_reg)) begin
                rot_cw        = 1'b1;
                reported_next = reported_reg + TICK_W'(1);
            end
            sticky_next = '0;
        end

        if (advance && in_req_reg == REQ_TICKS) begin
            tick_out = scaled;
            if (in_rebase_reg) begin
                baseline_next = step_sum_reg;
            end
        end

        m_tdata_next = {prev_pins_next, tick_out, rot_ccw, rot_cw,
                        sticky_out[STK_BACK_LONG], sticky_out[STK_ENC_LONG],
                        sticky_out[STK_BACK_SHORT], sticky_out[STK_ENC_SHORT],
                        held_next[1], held_next[0]};

        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_accept) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg    <= req_t'(s_tuser);
            in_pins_reg   <= s_tdata[PIN_W-1:0];
            in_stamp_reg  <= s_tdata[PIN_W +: STAMP_W];
            in_rebase_reg <= s_tdata[PIN_W + STAMP_W];
        end
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_variant_reg <= 1'b0;
            long_press_reg    <= LONG_PRESS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BOARD_VARIANT: board_variant_reg <= cfg_data[0];
                CFG_LONG_PRESS:    long_press_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            prev_pins_reg  <= '0;
            primed_reg     <= 1'b0;
            prev_quad_reg  <= '0;
            step_sum_reg   <= '0;
            baseline_reg   <= '0;
            reported_reg   <= '0;
            enc_stamp_reg  <= '0;
            back_stamp_reg <= '0;
            held_reg       <= '0;
            sticky_reg     <= '0;
        end else begin
            m_tvalid_reg   <= m_tvalid_next;
            prev_pins_reg  <= prev_pins_next;
            primed_reg     <= primed_next;
            prev_quad_reg  <= prev_quad_next;
            step_sum_reg   <= step_sum_next;
            baseline_reg   <= baseline_next;
            reported_reg   <= reported_next;
            enc_stamp_reg  <= enc_stamp_next;
            back_stamp_reg <= back_stamp_next;
            held_reg       <= held_next;
            sticky_reg     <= sticky_next;
        end
    end

`ifndef SYNTHESIS
    // A result never reports both rotation directions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[6] && m_tdata_reg[7]))
        else $error("both rotation directions reported");

    // The rotation tracker moves by at most one step per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (reported_reg == $past(reported_reg)
                            || reported_reg == $past(reported_reg) + TICK_W'(1)
                            || reported_reg == $past(reported_reg) - TICK_W'(1)))
        else $error("rotation tracker jumped");

    // An event read leaves the sticky flags cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg == REQ_EVENTS) |=> sticky_reg == '0)
        else $error("sticky flags not cleared by event read");

    // A beat waiting in the input register is never dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("pending input beat lost");

    // Held flags only change on a primed pin sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_req_reg == REQ_SAMPLE && primed_reg) |=> $stable(held_reg))
        else $error("held flags changed without a sample");
`endif

endmodule
`default_nettype wire

// ----- dv/ebet_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebet_event_checker
// Watches the sample, result and register channels of the encoder and button
// event tracker. It keeps its own copy of the decoder state, works out the
// report that each accepted sample or read should produce, and compares every
// result beat field by field against the oldest pending report.
// ----------------------------------------------------------------------------
module ebet_event_checker
    import ebet_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    reports_pending
);

    // Laid out so that the packed struct matches m_tdata bit for bit.
    typedef struct packed {
        logic [7:0]  pins;
        logic [31:0] ticks;
        logic        ccw;
        logic        cw;
        logic        back_long;
        logic        enc_long;
        logic        back_short;
        logic        enc_short;
        logic        back_held;
        logic        enc_held;
    } report_t;

    report_t     pending_reports[$];

    logic        variant;
    logic [31:0] long_limit;

    logic [7:0]  last_pins;
    logic        primed;
    logic [1:0]  last_quad;
    logic [31:0] step_total;
    logic [31:0] baseline;
    logic [31:0] tracker;
    logic [31:0] enc_stamp;
    logic [31:0] back_stamp;
    logic [1:0]  held;
    logic [3:0]  sticky;

    initial mismatch_count = 0;
    initial reports_pending = 0;

    // Step of one quadrature transition, indexed by {old pair, new pair}.
    function automatic logic [31:0] quad_move(input logic [3:0] idx);
        case (idx)
            4'd2, 4'd4, 4'd11, 4'd13: return 32'd1;
            4'd1, 4'd7, 4'd8, 4'd14: return 32'hFFFF_FFFF;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] scaled_delta();
        logic [31:0] d;
        d = step_total - baseline;
        if (variant) begin
            d = $unsigned($signed(d) >>> 2);
        end
        return d;
    endfunction

    function automatic void take_pins(input logic [7:0] pins, input logic [31:0] stamp);
        logic [1:0]  quad;
        logic [7:0]  rise;
        logic [7:0]  fall;
        logic [31:0] elapsed;
        quad = pins[PIN_QUAD_LO +: 2];
        if (!primed) begin
            // The very first snapshot only seeds the edge and pair history.
            last_pins = pins;
            last_quad = quad;
            primed    = 1'b1;
        end else begin
            rise = ~last_pins & pins;
            fall = last_pins & ~pins;
            if (fall[PIN_ENC_SW]) begin
                enc_stamp = stamp;
            end
            if (fall[PIN_BACK_SW]) begin
                back_stamp = stamp;
            end
            held = {~pins[PIN_BACK_SW], ~pins[PIN_ENC_SW]};
            if (rise[PIN_ENC_SW]) begin
                elapsed = stamp - enc_stamp;
                if (elapsed > long_limit) begin
                    sticky[STK_ENC_LONG] = 1'b1;
                end else begin
                    sticky[STK_ENC_SHORT] = 1'b1;
                end
            end
            if (rise[PIN_BACK_SW]) begin
                elapsed = stamp - back_stamp;
                if (elapsed > long_limit) begin
                    sticky[STK_BACK_LONG] = 1'b1;
                end else begin
                    sticky[STK_BACK_SHORT] = 1'b1;
                end
            end
            // The table counts the other way round, hence the subtract.
            step_total = step_total - quad_move({last_quad, quad});
            last_quad  = quad;
            last_pins  = pins;
        end
    endfunction

    function automatic report_t predict_report(input logic [1:0] req, input logic [7:0] pins,
                                               input logic [31:0] stamp, input logic rebase);
        report_t     r;
        logic [31:0] t;
        r = '0;
        if (req == REQ_SAMPLE) begin
            take_pins(pins, stamp);
        end
        r.enc_short  = sticky[STK_ENC_SHORT];
        r.back_short = sticky[STK_BACK_SHORT];
        r.enc_long   = sticky[STK_ENC_LONG];
        r.back_long  = sticky[STK_BACK_LONG];
        if (req == REQ_EVENTS) begin
            t = scaled_delta();
            if ($signed(t) < $signed(tracker)) begin
                r.ccw   = 1'b1;
                tracker = tracker - 32'd1;
            end else if ($signed(t) > $signed(tracker)) begin
                r.cw    = 1'b1;
                tracker = tracker + 32'd1;
            end
            sticky = '0;
        end else if (req == REQ_TICKS) begin
            r.ticks = scaled_delta();
            if (rebase) begin
                baseline = step_total;
            end
        end
        r.enc_held  = held[0];
        r.back_held = held[1];
        r.pins      = last_pins;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (!aresetn) begin
            pending_reports.delete();
            variant    = 1'b0;
            long_limit = LONG_PRESS_RESET;
            last_pins  = '0;
            primed     = 1'b0;
            last_quad  = '0;
            step_total = '0;
            baseline   = '0;
            tracker    = '0;
            enc_stamp  = '0;
            back_stamp = '0;
            held       = '0;
            sticky     = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = report_t'(m_tdata);
                if (pending_reports.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("enc_held", 32'(want.enc_held), 32'(got.enc_held));
                    check_field("back_held", 32'(want.back_held), 32'(got.back_held));
                    check_field("enc_short", 32'(want.enc_short), 32'(got.enc_short));
                    check_field("back_short", 32'(want.back_short), 32'(got.back_short));
                    check_field("enc_long", 32'(want.enc_long), 32'(got.enc_long));
                    check_field("back_long", 32'(want.back_long), 32'(got.back_long));
                    check_field("rot_cw", 32'(want.cw), 32'(got.cw));
                    check_field("rot_ccw", 32'(want.ccw), 32'(got.ccw));
                    check_field("tick_count", want.ticks, got.ticks);
                    check_field("pin_state", 32'(want.pins), 32'(got.pins));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BOARD_VARIANT) begin
                    variant = cfg_data[0];
                end else if (cfg_index == CFG_LONG_PRESS) begin
                    long_limit = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(predict_report(s_tuser, s_tdata[7:0],
                                                         s_tdata[39:8], s_tdata[40]));
            end
        end
        reports_pending = pending_reports.size();
    end

endmodule

// ----- dv/tb_encoder_button_event_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_button_event_tracker
// Drives pin samples, event reads, tick reads and unused request codes into
// the tracker under several register settings, with random idle bursts on
// both channels, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_encoder_button_event_tracker;
    import ebet_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          mismatch_count;
    int          reports_pending;
    logic        gaps_on = 1'b1;
    int          stall_left = 0;
    int          cycle_count = 0;

    // Stimulus-side model of the physical inputs.
    logic [1:0]  rot_pos = '0;
    logic        enc_down = 1'b0;
    logic        back_down = 1'b0;
    logic [31:0] stamp_clock;
    logic [31:0] press_limit = LONG_PRESS_RESET;

    encoder_button_event_tracker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ebet_event_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side stalls in random bursts while gaps are on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] req, input logic [7:0] pins,
                             input logic [31:0] stamp, input logic rebase);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, rebase, stamp, pins};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Returns on a rising edge once every predicted report has been checked.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (reports_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_board(input logic board, input logic [31:0] limit);
        wait_drained();
        write_reg(CFG_BOARD_VARIANT, {31'd0, board});
        write_reg(CFG_LONG_PRESS, limit);
        cfg_valid <= 1'b0;
        press_limit = limit;
    endtask

    function automatic logic [31:0] next_stamp_step();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 100);
            1: return press_limit + $urandom_range(0, 2) - 32'd1;
            2: return $urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(input int count);
        int          pick;
        logic [7:0]  pins;
        logic [1:0]  quad;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                stamp_clock = stamp_clock + next_stamp_step();
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any snapshot, including illegal pair jumps.
                    pins = 8'($urandom);
                    rot_pos   = {pins[2], pins[2] ^ pins[1]};
                    enc_down  = ~pins[PIN_ENC_SW];
                    back_down = ~pins[PIN_BACK_SW];
                end else begin
                    case ($urandom_range(0, 3))
                        1, 3: rot_pos = rot_pos + 2'd1;
                        2: rot_pos = rot_pos - 2'd1;
                        default: ;
                    endcase
                    if ($urandom_range(0, 5) == 0) begin
                        enc_down = ~enc_down;
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        back_down = ~back_down;
                    end
                    // Gray order of the pair: 00, 01, 11, 10.
                    quad = rot_pos ^ {1'b0, rot_pos[1]};
                    pins = 8'($urandom);
                    pins[PIN_QUAD_LO +: 2] = quad;
                    pins[PIN_ENC_SW]  = ~enc_down;
                    pins[PIN_BACK_SW] = ~back_down;
                end
                send_beat(REQ_SAMPLE, pins, stamp_clock, 1'($urandom_range(0, 1)));
            end else if (pick < 78) begin
                send_beat(REQ_EVENTS, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                send_beat(REQ_TICKS, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                send_beat(REQ_UNUSED, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        stamp_clock = $urandom;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads on the reset state, then the priming sample.
        send_beat(REQ_EVENTS, 8'h00, 32'h0, 1'b0);
        send_beat(REQ_TICKS, 8'h00, 32'h0, 1'b1);
        send_beat(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(REQ_SAMPLE, 8'hFF, 32'd0, 1'b0);
        // Both buttons pressed and released quickly.
        send_beat(REQ_SAMPLE, 8'h77, 32'd100, 1'b0);
        send_beat(REQ_SAMPLE, 8'hFF, 32'd200, 1'b0);
        send_beat(REQ_EVENTS, 8'h00, 32'd0, 1'b0);
        // A short press whose stamp wraps around zero.
        send_beat(REQ_SAMPLE, 8'h77, 32'hFFFF_FFF0, 1'b0);
        send_beat(REQ_SAMPLE, 8'hFF, 32'h0000_0010, 1'b0);
        // Releases exactly at and one past the long-press threshold.
        send_beat(REQ_SAMPLE, 8'h77, 32'd0, 1'b0);
        send_beat(REQ_SAMPLE, 8'hF7, LONG_PRESS_RESET, 1'b0);
        send_beat(REQ_SAMPLE, 8'hFF, LONG_PRESS_RESET + 32'd1, 1'b0);
        send_beat(REQ_EVENTS, 8'h00, 32'd0, 1'b0);
        send_beat(REQ_EVENTS, 8'h00, 32'd0, 1'b0);
        // One full detent cycle of the quadrature pair.
        send_beat(REQ_SAMPLE, 8'hFB, 32'd10, 1'b0);
        send_beat(REQ_SAMPLE, 8'hF9, 32'd20, 1'b0);
        send_beat(REQ_SAMPLE, 8'hFD, 32'd30, 1'b0);
        send_beat(REQ_SAMPLE, 8'hFF, 32'd40, 1'b0);
        send_beat(REQ_TICKS, 8'h00, 32'd0, 1'b0);
        send_beat(REQ_EVENTS, 8'h00, 32'd0, 1'b0);
        send_beat(REQ_EVENTS, 8'h00, 32'd0, 1'b0);
        send_beat(REQ_TICKS, 8'h00, 32'd0, 1'b1);
        send_beat(REQ_SAMPLE, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_beat(REQ_SAMPLE, 8'hFF, 32'h0000_0005, 1'b1);
        send_beat(REQ_TICKS, 8'h00, 32'd0, 1'b0);
        rot_pos   = 2'd2;
        enc_down  = 1'b0;
        back_down = 1'b0;

        set_board(1'b1, 32'd0);
        random_items(PHASE_ITEMS);
        set_board(1'b0, 32'hFFFF_FFFF);
        random_items(PHASE_ITEMS);
        set_board(1'b1, $urandom_range(100, 3000));
        random_items(PHASE_ITEMS);
        set_board(1'b0, LONG_PRESS_RESET);
        random_items(PHASE_ITEMS);
        set_board(1'b1, $urandom_range(0, 2000));
        gaps_on <= 1'b0;
        random_items(PHASE_ITEMS);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ebet_pkg.sv
rtl/encoder_button_event_tracker.sv
dv/ebet_event_checker.sv
dv/tb_encoder_button_event_tracker.sv
